// File: rtl/esdt_pkg.sv
// ----------------------------------------------------------------------------
// esdt_pkg
// Shared types, widths and constants of the soft-start differential throttle.
// ----------------------------------------------------------------------------
package esdt_pkg;

  // configurable widths
  localparam int DUTY_BITS     = 12;
  localparam int PCT_FRAC_BITS = 8;

  // fixed field widths
  localparam int CMD_W    = 3;
  localparam int PCT_W    = 15;               // unsigned Q7.8 percent
  localparam int RAMP_W   = 16;               // ramp accumulator
  localparam int STEER_W  = 16;               // signed Q8.8
  localparam int RATIO_W  = 12;               // unsigned Q4.8
  localparam int WIDE_FRAC = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = (DUTY_BITS > PCT_W) ? DUTY_BITS : PCT_W;

  // stream packing
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int IN_TGT_LSB   = 0;
  localparam int IN_STEP_LSB  = IN_TGT_LSB + PCT_W;
  localparam int IN_STEER_LSB = IN_STEP_LSB + PCT_W;
  localparam int IN_USED_W    = IN_STEER_LSB + STEER_W;
  localparam int OUT_LEFT_LSB  = 0;
  localparam int OUT_RIGHT_LSB = DUTY_BITS;
  localparam int OUT_RAMP_BIT  = 2 * DUTY_BITS;
  localparam int OUT_USED_W    = OUT_RAMP_BIT + 1;

  // whole-percent and duty arithmetic widths
  localparam int PCT_INT_W = RAMP_W - PCT_FRAC_BITS;
  localparam int P_W       = (PCT_INT_W > 7) ? PCT_INT_W : 7;  // whole percent
  localparam int SUM_W     = P_W + 1;                          // 100 + p
  localparam int PROD_W    = DUTY_BITS + SUM_W;                // min_duty * (100 + p)
  localparam int DIV_SHIFT = PROD_W + 7;
  localparam int MUL_W     = DIV_SHIFT - 6;
  localparam int QW        = PROD_W - 6;                       // prod / 100
  localparam logic [63:0] DIV_MUL_FULL = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;
  localparam logic [MUL_W-1:0] DIV_MUL = DIV_MUL_FULL[MUL_W-1:0];

  // differential mix widths
  localparam int DIFF_W = STEER_W + RATIO_W + 1;
  localparam int MIX_W  = 32;
  localparam int LIFT   = WIDE_FRAC - PCT_FRAC_BITS;

  localparam logic [DUTY_BITS-1:0] START_DUTY = DUTY_BITS'(625);
  localparam logic [SUM_W-1:0]     PCT_FULL   = SUM_W'(100);

  // register reset values
  localparam logic [DUTY_BITS-1:0] MIN_DUTY_RST   = DUTY_BITS'(500);
  localparam logic [DUTY_BITS-1:0] MAX_DUTY_RST   = DUTY_BITS'(1000);
  localparam logic [RATIO_W-1:0]   DIFF_RATIO_RST = RATIO_W'(256);
  localparam logic [PCT_W-1:0]     DIFF_LIMIT_RST = PCT_W'(3840);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DUTY    = 3'd0,
    REG_MAX_DUTY    = 3'd1,
    REG_DIFF_ENABLE = 3'd2,
    REG_DIFF_RATIO  = 3'd3,
    REG_DIFF_LIMIT  = 3'd4
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_INIT       = 3'd1,
    CMD_START      = 3'd2,
    CMD_SOFT_START = 3'd3,
    CMD_STOP       = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] min_duty;
    logic [DUTY_BITS-1:0] max_duty;
    logic                 diff_enable;
    logic [RATIO_W-1:0]   diff_ratio;
    logic [PCT_W-1:0]     diff_limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic mix;
    logic scale;
    logic div;
    logic write;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/esdt_cfg.sv
// ----------------------------------------------------------------------------
// esdt_cfg
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module esdt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [esdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output esdt_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_duty    <= esdt_pkg::MIN_DUTY_RST;
      cfg.max_duty    <= esdt_pkg::MAX_DUTY_RST;
      cfg.diff_enable <= 1'b0;
      cfg.diff_ratio  <= esdt_pkg::DIFF_RATIO_RST;
      cfg.diff_limit  <= esdt_pkg::DIFF_LIMIT_RST;
    end else if (cfg_valid) begin
      // unknown indexes are dropped
      case (cfg_index)
        esdt_pkg::REG_MIN_DUTY:    cfg.min_duty    <= cfg_data[esdt_pkg::DUTY_BITS-1:0];
        esdt_pkg::REG_MAX_DUTY:    cfg.max_duty    <= cfg_data[esdt_pkg::DUTY_BITS-1:0];
        esdt_pkg::REG_DIFF_ENABLE: cfg.diff_enable <= cfg_data[0];
        esdt_pkg::REG_DIFF_RATIO:  cfg.diff_ratio  <= cfg_data[esdt_pkg::RATIO_W-1:0];
        esdt_pkg::REG_DIFF_LIMIT:  cfg.diff_limit  <= cfg_data[esdt_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/esdt_ctrl.sv
// ----------------------------------------------------------------------------
// esdt_ctrl
// Sequencer: steps one command word through execute, mix, scale, divide and
// write-back; a command that gives no result goes back to idle after execute.
// ----------------------------------------------------------------------------
module esdt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  esdt_pkg::stat_t stat,
  output esdt_pkg::ctrl_t ctrl
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_MIX   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_WRITE = 6'b100000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = stat.has_result ? ST_MIX : ST_IDLE;
      end
      ST_MIX: begin
        ctrl.mix   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        ctrl.scale = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          ctrl.write = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/esdt_dp.sv
// ----------------------------------------------------------------------------
// esdt_dp
// Datapath: run state, ramp accumulator, steering mix, percent to duty
// conversion and the output register.
// ----------------------------------------------------------------------------
module esdt_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  esdt_pkg::ctrl_t                       ctrl,
  output esdt_pkg::stat_t                       stat,
  input  esdt_pkg::cfg_t                        cfg,
  input  logic [esdt_pkg::CMD_W-1:0]            in_cmd,
  input  logic [esdt_pkg::PCT_W-1:0]            in_soft_target,
  input  logic [esdt_pkg::PCT_W-1:0]            in_ramp_inc,
  input  logic signed [esdt_pkg::STEER_W-1:0]   in_steer_adjust,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [esdt_pkg::DUTY_BITS-1:0]        duty_left,
  output logic [esdt_pkg::DUTY_BITS-1:0]        duty_right,
  output logic                                  ramping
);

  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_MIN   = 2'd1,
    KIND_PCT   = 2'd2
  } kind_t;

  // run state
  logic                            armed, running, soft_active;
  logic [esdt_pkg::PCT_W-1:0]      base_level, step_size;
  logic [esdt_pkg::RAMP_W-1:0]     ramp_level;

  // captured command word
  esdt_pkg::cmd_t                  cmd_r;
  logic [esdt_pkg::PCT_W-1:0]      target_r, step_r;
  logic signed [esdt_pkg::STEER_W-1:0] steer_r;

  // per-item working registers
  kind_t                           kind_r;
  logic                            use_mix_r, ramping_r;
  logic [esdt_pkg::P_W-1:0]        p_left, p_right;
  logic signed [esdt_pkg::DIFF_W-1:0] steer_prod;
  logic [esdt_pkg::PROD_W-1:0]     prod_left, prod_right;
  logic [esdt_pkg::QW-1:0]         q_left, q_right;

  // ramp step
  logic [esdt_pkg::RAMP_W:0]       ramp_sum;
  logic [esdt_pkg::RAMP_W-1:0]     ramp_sat, ramp_new;
  logic                            ramp_done;

  always_comb begin
    ramp_sum  = {1'b0, ramp_level} + {2'b0, step_size};
    ramp_sat  = ramp_sum[esdt_pkg::RAMP_W] ? '1 : ramp_sum[esdt_pkg::RAMP_W-1:0];
    ramp_done = ramp_sat >= {1'b0, base_level};
    ramp_new  = ramp_done ? {1'b0, base_level} : ramp_sat;
  end

  always_comb begin
    priority case (cmd_r)
      esdt_pkg::CMD_START: stat.has_result = armed;
      esdt_pkg::CMD_STOP:  stat.has_result = 1'b1;
      esdt_pkg::CMD_TICK:  stat.has_result = running & armed;
      default:             stat.has_result = 1'b0;
    endcase
    stat.out_free = ~out_valid | out_ready;
  end

  // steering mix, all in 16 fraction bits
  logic signed [esdt_pkg::MIX_W-1:0] lim_w, base_w, diff_w, diff_c, lt_w, rt_w;
  logic signed [esdt_pkg::MIX_W-1:0] lt_c, rt_c, full_w;

  always_comb begin
    full_w = esdt_pkg::MIX_W'(esdt_pkg::PCT_FULL) << esdt_pkg::WIDE_FRAC;
    lim_w  = esdt_pkg::MIX_W'(cfg.diff_limit) << esdt_pkg::LIFT;
    base_w = esdt_pkg::MIX_W'(base_level) << esdt_pkg::LIFT;
    diff_w = {{(esdt_pkg::MIX_W - esdt_pkg::DIFF_W){steer_prod[esdt_pkg::DIFF_W-1]}},
              steer_prod};
    if (diff_w < -lim_w) begin
      diff_c = -lim_w;
    end else if (diff_w > lim_w) begin
      diff_c = lim_w;
    end else begin
      diff_c = diff_w;
    end
    lt_w = base_w - diff_c;
    rt_w = base_w + diff_c;
    lt_c = (lt_w < 0) ? '0 : ((lt_w > full_w) ? full_w : lt_w);
    rt_c = (rt_w < 0) ? '0 : ((rt_w > full_w) ? full_w : rt_w);
  end

  // reciprocal multiply for the divide by 100
  logic [esdt_pkg::PROD_W+esdt_pkg::MUL_W-1:0] div_left, div_right;

  always_comb begin
    div_left  = {{esdt_pkg::MUL_W{1'b0}}, prod_left} *
                {{esdt_pkg::PROD_W{1'b0}}, esdt_pkg::DIV_MUL};
    div_right = {{esdt_pkg::MUL_W{1'b0}}, prod_right} *
                {{esdt_pkg::PROD_W{1'b0}}, esdt_pkg::DIV_MUL};
  end

  function automatic logic [esdt_pkg::DUTY_BITS-1:0] duty_clamp(
    input logic [esdt_pkg::QW-1:0]        q,
    input logic [esdt_pkg::DUTY_BITS-1:0] lo,
    input logic [esdt_pkg::DUTY_BITS-1:0] hi
  );
    logic [esdt_pkg::QW-1:0] d;
    d = q;
    if (d > esdt_pkg::QW'(hi)) d = esdt_pkg::QW'(hi);
    if (d < esdt_pkg::QW'(lo)) d = esdt_pkg::QW'(lo);
    return d[esdt_pkg::DUTY_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= esdt_pkg::cmd_t'(in_cmd);
      target_r <= in_soft_target;
      step_r   <= in_ramp_inc;
      steer_r  <= in_steer_adjust;
    end
    if (ctrl.exec) begin
      steer_prod <= steer_r * $signed({1'b0, cfg.diff_ratio});
      use_mix_r  <= 1'b0;
      ramping_r  <= 1'b0;
      kind_r     <= KIND_PCT;
      priority case (cmd_r)
        esdt_pkg::CMD_START: kind_r <= KIND_FIXED;
        esdt_pkg::CMD_STOP:  kind_r <= KIND_MIN;
        esdt_pkg::CMD_TICK: begin
          if (soft_active) begin
            ramping_r <= ~ramp_done;
            p_left    <= esdt_pkg::P_W'(ramp_new[esdt_pkg::RAMP_W-1:esdt_pkg::PCT_FRAC_BITS]);
            p_right   <= esdt_pkg::P_W'(ramp_new[esdt_pkg::RAMP_W-1:esdt_pkg::PCT_FRAC_BITS]);
          end else begin
            use_mix_r <= cfg.diff_enable;
            p_left    <= esdt_pkg::P_W'(base_level[esdt_pkg::PCT_W-1:esdt_pkg::PCT_FRAC_BITS]);
            p_right   <= esdt_pkg::P_W'(base_level[esdt_pkg::PCT_W-1:esdt_pkg::PCT_FRAC_BITS]);
          end
        end
        default: ;
      endcase
    end
    if (ctrl.mix && use_mix_r) begin
      p_left  <= lt_c[esdt_pkg::WIDE_FRAC +: esdt_pkg::P_W];
      p_right <= rt_c[esdt_pkg::WIDE_FRAC +: esdt_pkg::P_W];
    end
    if (ctrl.scale) begin
      prod_left  <= esdt_pkg::PROD_W'(cfg.min_duty) *
                    esdt_pkg::PROD_W'({1'b0, p_left} + esdt_pkg::PCT_FULL);
      prod_right <= esdt_pkg::PROD_W'(cfg.min_duty) *
                    esdt_pkg::PROD_W'({1'b0, p_right} + esdt_pkg::PCT_FULL);
    end
    if (ctrl.div) begin
      q_left  <= div_left[esdt_pkg::DIV_SHIFT +: esdt_pkg::QW];
      q_right <= div_right[esdt_pkg::DIV_SHIFT +: esdt_pkg::QW];
    end
    if (ctrl.write) begin
      ramping <= ramping_r;
      unique case (kind_r)
        KIND_FIXED: begin
          duty_left  <= esdt_pkg::START_DUTY;
          duty_right <= esdt_pkg::START_DUTY;
        end
        KIND_MIN: begin
          duty_left  <= cfg.min_duty;
          duty_right <= cfg.min_duty;
        end
        default: begin
          duty_left  <= duty_clamp(q_left, cfg.min_duty, cfg.max_duty);
          duty_right <= duty_clamp(q_right, cfg.min_duty, cfg.max_duty);
        end
      endcase
    end
  end

  // run state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      running     <= 1'b0;
      soft_active <= 1'b0;
      base_level  <= '0;
      ramp_level  <= '0;
      step_size   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.exec) begin
        priority case (cmd_r)
          esdt_pkg::CMD_INIT: begin
            armed       <= 1'b1;
            running     <= 1'b0;
            soft_active <= 1'b0;
          end
          esdt_pkg::CMD_START: begin
            running     <= 1'b1;
            soft_active <= 1'b0;
          end
          esdt_pkg::CMD_SOFT_START: begin
            base_level  <= target_r;
            step_size   <= step_r;
            ramp_level  <= '0;
            soft_active <= 1'b1;
            running     <= 1'b1;
          end
          esdt_pkg::CMD_STOP: begin
            running     <= 1'b0;
            soft_active <= 1'b0;
            base_level  <= '0;
            ramp_level  <= '0;
          end
          esdt_pkg::CMD_TICK: begin
            if (running && armed && soft_active) begin
              ramp_level  <= ramp_new;
              soft_active <= ~ramp_done;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/esc_soft_start_diff_throttle.sv
// ----------------------------------------------------------------------------
// esc_soft_start_diff_throttle
// Two-channel throttle sequencer with soft-start ramp and steering mix.
// ----------------------------------------------------------------------------
// One command word is handled at a time. A command that gives no duty word
// (init, soft_start, an unarmed start, an idle tick, an unknown code) passes
// through execute and back to idle before the next word can be accepted; one
// that gives a duty word goes through execute, steering mix, the min_duty
// multiply, the reciprocal multiply that divides by 100, then write into the
// output register. The output register holds a finished word while the next
// command is already accepted and worked on; only the final write waits for
// the register to be free. Configuration writes complete in the cycle they
// are presented and are meant to be made while no command is in flight.
module esc_soft_start_diff_throttle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // soft_target[14:0], ramp_inc[29:15], steer_adjust[45:30], zero fill
  input  logic [esdt_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd[2:0]
  input  logic [esdt_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // duty_left[11:0], duty_right[23:12], ramping[24], zero fill
  output logic [esdt_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [esdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esdt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  esdt_pkg::cfg_t  cfg;
  esdt_pkg::ctrl_t ctrl;
  esdt_pkg::stat_t stat;

  logic [esdt_pkg::DUTY_BITS-1:0] duty_left, duty_right;
  logic                           ramping;

  esdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  esdt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .stat            (stat),
    .cfg             (cfg),
    .in_cmd          (s_tuser),
    .in_soft_target  (s_tdata[esdt_pkg::IN_TGT_LSB +: esdt_pkg::PCT_W]),
    .in_ramp_inc     (s_tdata[esdt_pkg::IN_STEP_LSB +: esdt_pkg::PCT_W]),
    .in_steer_adjust ($signed(s_tdata[esdt_pkg::IN_STEER_LSB +: esdt_pkg::STEER_W])),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .duty_left       (duty_left),
    .duty_right      (duty_right),
    .ramping         (ramping)
  );

  assign m_tdata = {{(esdt_pkg::OUT_DATA_W - esdt_pkg::OUT_USED_W){1'b0}},
                    ramping, duty_right, duty_left};

endmodule
